// ----- sv/sbfd_pkg.sv -----
`default_nettype none

package sbfd_pkg;

   // Defaults of the frame geometry
   localparam int DATA_BYTES_DEF   = 22;
   localparam int CHANNEL_BITS_DEF = 11;
   localparam int CHANNELS_DEF     = 16;

   // Fixed field widths
   localparam int BYTE_BITS   = 8;
   localparam int INDEX_BITS  = 4;
   localparam int VALUE_BITS  = 11;

   // Framing bytes
   localparam logic [BYTE_BITS-1:0] START_BYTE = 8'h0F;
   localparam logic [BYTE_BITS-1:0] END_BYTE   = 8'h00;

   // Controller -> datapath
   typedef struct packed {
      logic cnt_clear;     // restart data byte count
      logic byte_shift;    // shift received byte into frame register
      logic ch_clear;      // restart channel counter
      logic out_load_ch;   // load next channel into output register
      logic out_load_err;  // load frame-error result into output register
   } sbfd_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic is_start;      // received byte is the start byte
      logic is_end;        // received byte is a good end byte
      logic count_done;    // this data byte is the final one
      logic ch_last;       // channel counter on final channel
      logic out_free;      // output register can take a result this cycle
   } sbfd_sts_type;

endpackage

`default_nettype wire

// ----- sv/sbfd_datapath.sv -----
`default_nettype none

module sbfd_datapath #(
   parameter int DATA_BYTES   = sbfd_pkg::DATA_BYTES_DEF,
   parameter int CHANNEL_BITS = sbfd_pkg::CHANNEL_BITS_DEF,
   parameter int CHANNELS     = sbfd_pkg::CHANNELS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [sbfd_pkg::BYTE_BITS-1:0]  req_rx_byte,
   input  wire sbfd_pkg::sbfd_cmd_type          cmd,
   output sbfd_pkg::sbfd_sts_type               sts,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic [sbfd_pkg::INDEX_BITS-1:0]      rsp_channel_index,
   output logic [sbfd_pkg::VALUE_BITS-1:0]      rsp_channel_value,
   output logic                                 rsp_frame_error,
   output logic                                 rsp_last
);

   localparam int BUF_BITS = DATA_BYTES * sbfd_pkg::BYTE_BITS;
   localparam int EXT_BITS = BUF_BITS + CHANNEL_BITS;
   localparam int CNT_BITS = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
   localparam int IB       = sbfd_pkg::INDEX_BITS;
   localparam int VB       = sbfd_pkg::VALUE_BITS;

   // Frame register: bytes shift in at the top, so byte k ends at bit 8k.
   // Channels leave at the bottom; zeros fill from above.
   logic [BUF_BITS-1:0]     frame_ff, frame_in;
   logic [EXT_BITS-1:0]     frame_ext;
   logic [CHANNEL_BITS-1:0] ch_bits;

   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [IB-1:0]           ch_ff, ch_in;

   logic                    valid_ff, valid_in;
   logic [IB-1:0]           index_ff, index_in;
   logic [VB-1:0]           value_ff, value_in;
   logic                    error_ff, error_in;
   logic                    last_ff, last_in;

   assign frame_ext = {{CHANNEL_BITS{1'b0}}, frame_ff};
   assign ch_bits   = frame_ext[CHANNEL_BITS-1:0];

   always_comb begin
      frame_in = frame_ff;
      if (cmd.byte_shift) begin
         if (BUF_BITS > sbfd_pkg::BYTE_BITS) begin
            frame_in = BUF_BITS'({req_rx_byte, frame_ff} >> sbfd_pkg::BYTE_BITS);
         end else begin
            frame_in = BUF_BITS'(req_rx_byte);
         end
      end else if (cmd.out_load_ch) begin
         frame_in = frame_ext[CHANNEL_BITS +: BUF_BITS];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.byte_shift) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_comb begin
      ch_in = ch_ff;
      if (cmd.ch_clear) begin
         ch_in = '0;
      end else if (cmd.out_load_ch) begin
         ch_in = ch_ff + IB'(1);
      end
   end

   // Output register
   always_comb begin
      valid_in = valid_ff && rsp_stall;
      index_in = index_ff;
      value_in = value_ff;
      error_in = error_ff;
      last_in  = last_ff;
      if (cmd.out_load_ch) begin
         valid_in = 1'b1;
         index_in = ch_ff;
         value_in = VB'(ch_bits);
         error_in = 1'b0;
         last_in  = sts.ch_last;
      end else if (cmd.out_load_err) begin
         valid_in = 1'b1;
         index_in = '0;
         value_in = '0;
         error_in = 1'b1;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         ch_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         ch_ff    <= ch_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      index_ff <= index_in;
      value_ff <= value_in;
      error_ff <= error_in;
      last_ff  <= last_in;
   end

   assign sts.is_start   = (req_rx_byte == sbfd_pkg::START_BYTE);
   assign sts.is_end     = (req_rx_byte == sbfd_pkg::END_BYTE);
   assign sts.count_done = (cnt_ff == CNT_BITS'(DATA_BYTES - 1));
   assign sts.ch_last    = (ch_ff == IB'(CHANNELS - 1));
   assign sts.out_free   = !valid_ff || !rsp_stall;

   assign rsp_valid         = valid_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_frame_error   = error_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

// ----- sv/sbfd_ctrl.sv -----
`default_nettype none

module sbfd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire sbfd_pkg::sbfd_sts_type  sts,
   output sbfd_pkg::sbfd_cmd_type       cmd
);

   localparam logic [2:0] ST_HUNT  = 3'd0;
   localparam logic [2:0] ST_DATA  = 3'd1;
   localparam logic [2:0] ST_FLAGS = 3'd2;
   localparam logic [2:0] ST_END   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       in_fire;

   assign req_stall = (state_ff == ST_EMIT) || !sts.out_free;
   assign in_fire   = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_HUNT: begin
            if (in_fire && sts.is_start) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_DATA;
            end
         end
         ST_DATA: begin
            if (in_fire) begin
               cmd.byte_shift = 1'b1;
               if (sts.count_done) begin
                  state_in = ST_FLAGS;
               end
            end
         end
         ST_FLAGS: begin
            if (in_fire) begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            if (in_fire) begin
               if (sts.is_end) begin
                  cmd.ch_clear = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  cmd.out_load_err = 1'b1;
                  state_in         = ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load_ch = 1'b1;
               if (sts.ch_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/sbus_frame_decoder_core.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_rx_byte[7:0]
// rsp       out        rsp_valid / rsp_stall  rsp_channel_index[3:0], rsp_channel_value[10:0],
//                                             rsp_frame_error, rsp_last
//
// A good end byte is followed by emission of CHANNELS channels (16 by default),
// one channel per cycle out of the frame shift register while rsp is not stalled,
// during which req is stalled; rsp stalls extend emission. req also stalls while a
// result sits in the output register and rsp_stall is high.
// Reset is synchronous, active high; it returns the block to hunting for the
// start byte. Frame storage has no reset: a frame is fully reloaded before use.

module sbus_frame_decoder_core #(
   parameter int DATA_BYTES   = sbfd_pkg::DATA_BYTES_DEF,
   parameter int CHANNEL_BITS = sbfd_pkg::CHANNEL_BITS_DEF,
   parameter int CHANNELS     = sbfd_pkg::CHANNELS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // received byte transactions
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sbfd_pkg::BYTE_BITS-1:0]  req_rx_byte,
   // decoded channel / frame-error transactions
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [sbfd_pkg::INDEX_BITS-1:0]      rsp_channel_index,
   output logic [sbfd_pkg::VALUE_BITS-1:0]      rsp_channel_value,
   output logic                                 rsp_frame_error,
   output logic                                 rsp_last
);

   // Command and status between sequencer and datapath
   sbfd_pkg::sbfd_cmd_type cmd;
   sbfd_pkg::sbfd_sts_type sts;

   // Sequencer: hunt -> data -> flags -> end -> (emit) -> hunt
   sbfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: frame shift register, byte and channel counters, output register
   sbfd_datapath #(
      .DATA_BYTES   (DATA_BYTES),
      .CHANNEL_BITS (CHANNEL_BITS),
      .CHANNELS     (CHANNELS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_frame_error   (rsp_frame_error),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;

   localparam int NUM_DATA    = sbfd_pkg::DATA_BYTES_DEF;
   localparam int CH_BITS     = sbfd_pkg::CHANNEL_BITS_DEF;
   localparam int NUM_CH      = sbfd_pkg::CHANNELS_DEF;
   localparam int STRING_BITS = NUM_DATA * sbfd_pkg::BYTE_BITS;
   // room for channels that would run past the stored bits
   localparam int PADDED_BITS = STRING_BITS + NUM_CH * CH_BITS;
   localparam int MAX_GAP     = 17;
   localparam int LONG_HOLD   = 300;

   typedef enum logic [1:0] {HUNTING, IN_DATA, AT_FLAGS, AT_END} frame_phase_type;

   typedef struct {
      logic [sbfd_pkg::INDEX_BITS-1:0] index;
      logic [sbfd_pkg::VALUE_BITS-1:0] value;
      logic                            frame_error;
      logic                            last;
   } chan_result_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [sbfd_pkg::BYTE_BITS-1:0]  req_rx_byte;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [sbfd_pkg::INDEX_BITS-1:0] rsp_channel_index;
   logic [sbfd_pkg::VALUE_BITS-1:0] rsp_channel_value;
   logic                            rsp_frame_error;
   logic                            rsp_last;

   // frame decoder mirror
   frame_phase_type                rx_phase;
   logic [4:0]                     data_count;
   logic [sbfd_pkg::BYTE_BITS-1:0] frame_store [NUM_DATA];
   chan_result_type                pending_channels [$];

   logic [sbfd_pkg::BYTE_BITS-1:0] frame_data [NUM_DATA];
   bit                             sender_idles;
   bit                             receiver_idles;
   int                             hold_off_cycles;
   int                             bytes_sent;
   int                             good_frames;
   int                             bad_frames;
   int                             results_checked;
   int                             failures;

   sbus_frame_decoder_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_frame_error   (rsp_frame_error),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[sbus_frame_decoder_core] ERROR");
      $finish;
   end

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   // Advance the frame mirror by one accepted byte; queue whatever it emits.
   function automatic void decode_rx_byte(logic [sbfd_pkg::BYTE_BITS-1:0] b);
      bit [PADDED_BITS-1:0] bits;
      chan_result_type      r;
      int                   i;
      int                   ch;
      case (rx_phase)
         HUNTING: begin
            if (b == sbfd_pkg::START_BYTE) begin
               rx_phase   = IN_DATA;
               data_count = '0;
            end
         end
         IN_DATA: begin
            // start byte here is plain data
            frame_store[data_count] = b;
            data_count++;
            if (data_count >= NUM_DATA) begin
               rx_phase = AT_FLAGS;
            end
         end
         AT_FLAGS: begin
            rx_phase = AT_END;
         end
         AT_END: begin
            if (b == sbfd_pkg::END_BYTE) begin
               // little-endian bit string, zero past the stored bytes
               bits = '0;
               for (i = 0; i < NUM_DATA; i++) begin
                  bits[i*sbfd_pkg::BYTE_BITS +: sbfd_pkg::BYTE_BITS] = frame_store[i];
               end
               for (ch = 0; ch < NUM_CH; ch++) begin
                  r.index       = sbfd_pkg::INDEX_BITS'(ch);
                  r.value       = sbfd_pkg::VALUE_BITS'(bits[ch*CH_BITS +: CH_BITS]);
                  r.frame_error = 1'b0;
                  r.last        = (ch == NUM_CH - 1);
                  pending_channels.push_back(r);
               end
               good_frames++;
            end else begin
               r.index       = '0;
               r.value       = '0;
               r.frame_error = 1'b1;
               r.last        = 1'b1;
               pending_channels.push_back(r);
               bad_frames++;
            end
            rx_phase   = HUNTING;
            data_count = '0;
         end
      endcase
   endfunction

   function automatic logic [sbfd_pkg::BYTE_BITS-1:0] rand_byte(int lo, int hi);
      return sbfd_pkg::BYTE_BITS'($urandom_range(lo, hi));
   endfunction

   // One byte transaction; valid stays up across back-to-back bytes.
   task automatic send_byte(input logic [sbfd_pkg::BYTE_BITS-1:0] b);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      decode_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [sbfd_pkg::BYTE_BITS-1:0] flags,
                             input logic [sbfd_pkg::BYTE_BITS-1:0] tail);
      int i;
      send_byte(sbfd_pkg::START_BYTE);
      for (i = 0; i < NUM_DATA; i++) begin
         send_byte(frame_data[i]);
      end
      send_byte(flags);
      send_byte(tail);
   endtask

   task automatic fill_random_frame();
      int i;
      for (i = 0; i < NUM_DATA; i++) begin
         frame_data[i] = rand_byte(0, 255);
      end
   endtask

   // Mostly well-formed frames, some line noise, some frames cut short.
   task automatic send_random_sequence();
      int                             pick;
      logic [sbfd_pkg::BYTE_BITS-1:0] tail;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         fill_random_frame();
         tail = ($urandom_range(0, 3) == 0) ? rand_byte(1, 255)
                                            : sbfd_pkg::END_BYTE;
         send_frame(rand_byte(0, 255), tail);
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 4)) send_byte(rand_byte(0, 255));
      end else begin
         send_byte(sbfd_pkg::START_BYTE);
         repeat ($urandom_range(0, NUM_DATA - 1)) send_byte(rand_byte(0, 255));
      end
   endtask

   // bytes while hunting, none of them the start byte
   task automatic test_idle_bytes();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hF0);
      send_byte(8'h0E);
      send_byte(8'h10);
   endtask

   // full-scale first channel, zero last channel, start bytes inside data,
   // then a frame closed by a bad end byte
   task automatic test_known_frames();
      int i;
      for (i = 0; i < NUM_DATA; i++) begin
         frame_data[i] = sbfd_pkg::BYTE_BITS'(i * 37 + 1);
      end
      frame_data[0]            = 8'hFF;
      frame_data[1]            = 8'hFF;
      frame_data[2]            = 8'hFF;
      frame_data[3]            = 8'h00;
      frame_data[4]            = sbfd_pkg::START_BYTE;
      frame_data[5]            = sbfd_pkg::START_BYTE;
      frame_data[NUM_DATA - 2] = 8'h00;
      frame_data[NUM_DATA - 1] = 8'h00;
      send_frame(8'hFF, sbfd_pkg::END_BYTE);
      for (i = 0; i < NUM_DATA; i++) begin
         frame_data[i] = sbfd_pkg::BYTE_BITS'(i);
      end
      send_frame(8'h00, sbfd_pkg::START_BYTE);
   endtask

   task automatic test_steady_flow();
      int stop_at;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      stop_at        = bytes_sent + 15;
      while (bytes_sent < stop_at) send_random_sequence();
   endtask

   task automatic test_random_traffic();
      int stop_at;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      stop_at        = bytes_sent + 25;
      while (bytes_sent < stop_at) send_random_sequence();
   endtask

   // receiver sits on a result for a long time while frames keep coming
   task automatic test_backpressure();
      sender_idles    = 1'b0;
      receiver_idles  = 1'b0;
      hold_off_cycles = LONG_HOLD;
      repeat (2) begin
         fill_random_frame();
         send_frame(rand_byte(0, 255), sbfd_pkg::END_BYTE);
      end
   endtask

   // result side: draws a stall per transaction, then checks it
   initial begin : rsp_checker
      int              stall_len;
      chan_result_type want;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off_cycles > 0) begin
            stall_len       = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall_len = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         results_checked++;
         if (pending_channels.size() == 0) begin
            note_failure($sformatf("unexpected result: index %0d value %0d ferr %b last %b",
                                   rsp_channel_index, rsp_channel_value,
                                   rsp_frame_error, rsp_last));
         end else begin
            want = pending_channels.pop_front();
            if (rsp_channel_index !== want.index || rsp_channel_value !== want.value ||
                rsp_frame_error !== want.frame_error || rsp_last !== want.last) begin
               note_failure($sformatf(
                  "mismatch: exp index %0d value %0d ferr %b last %b, got %0d %0d %b %b",
                  want.index, want.value, want.frame_error, want.last,
                  rsp_channel_index, rsp_channel_value, rsp_frame_error, rsp_last));
            end
         end
      end
   end

   initial begin : test_sequence
      int waited;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_rx_byte     <= '0;
      rx_phase         = HUNTING;
      data_count       = '0;
      sender_idles     = 1'b1;
      receiver_idles   = 1'b1;
      hold_off_cycles  = 0;
      bytes_sent       = 0;
      good_frames      = 0;
      bad_frames       = 0;
      results_checked  = 0;
      failures         = 0;
      waited           = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_bytes();
      test_known_frames();
      test_steady_flow();
      test_random_traffic();
      test_backpressure();
      req_valid <= 1'b0;

      // drain, then leave room for anything stray
      while (pending_channels.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (pending_channels.size() != 0) begin
         note_failure($sformatf("%0d expected results never arrived",
                                pending_channels.size()));
      end

      $display("Sent %0d bytes: %0d good frames, %0d frames with a bad end byte.",
               bytes_sent, good_frames, bad_frames);
      $display("Checked %0d results, %0d failures.", results_checked, failures);
      if (failures == 0) begin
         $display("[sbus_frame_decoder_core] OK");
      end else begin
         $display("[sbus_frame_decoder_core] ERROR");
      end
      $finish;
   end

endmodule
